>>> design/pgw_pkg.sv
// Shared types, codes and constants for the two-level page walker.
`timescale 1ns / 1ps
package pgw_pkg;

   localparam int unsigned AddrWidth  = 32;
   localparam int unsigned PfnWidth   = 20;
   localparam int unsigned DirShift   = 22;
   localparam int unsigned TblShift   = 12;
   localparam int unsigned IdxWidth   = 10;
   localparam int unsigned LargeBit   = 7;
   localparam int unsigned CsrIdxWidth  = 8;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned ReqDataWidth = 64;
   localparam int unsigned RspDataWidth = 72;

   localparam logic [1:0] PHASE_IDLE = 2'd0;
   localparam logic [1:0] PHASE_DIR  = 2'd1;
   localparam logic [1:0] PHASE_TBL  = 2'd2;

   localparam logic [1:0] KIND_READ = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   localparam logic       CMD_TRANSLATE = 1'b0;
   localparam logic       CMD_DATA      = 1'b1;

   localparam logic [CsrIdxWidth-1:0] CSR_PAGING_ENABLED = 8'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_PAGE_DIR_BASE  = 8'd1;

   typedef struct packed {
      logic [1:0]           phase;
      logic [AddrWidth-1:0] held_lin_addr;
      logic                 paging_enabled;
      logic [PfnWidth-1:0]  page_dir_base;
   } walk_state_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [AddrWidth-1:0] mem_addr;
      logic [AddrWidth-1:0] phys_addr;
      logic                 ok;
      logic                 writable;
   } walk_result_type;

   typedef struct packed {
      logic [1:0] next_phase;
      logic       load_held;
   } walk_update_type;

endpackage

>>> design/two_level_page_walker.sv
// Top level of the two-level page walker: walk state, CSRs and result register.
// An accepted request's response is formed combinationally and is held in the output register in the next cycle.
// Throughput: one request per cycle; req_tready drops only while a response is stalled or reset is high.
// The single output register holding the response sets this figure.
// Reset (synchronous): walk idle, paging off, directory base zero, no response pending.
`timescale 1ns / 1ps
module two_level_page_walker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pgw_pkg::ReqDataWidth-1:0] req_tdata,  // lin_addr, read_data
   input  logic                             req_tuser,  // command
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pgw_pkg::RspDataWidth-1:0] rsp_tdata,  // mem_addr, phys_addr, ok, writable, pad
   output logic [1:0]                       rsp_tuser,  // kind
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pgw_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [pgw_pkg::CsrDataWidth-1:0] csr_data
);
   import pgw_pkg::*;

   logic                 req_accept;
   walk_state_type       state;
   walk_result_type      result;
   walk_update_type      update;

   logic [1:0]           phase_ff,   phase_in;
   logic [AddrWidth-1:0] held_ff,    held_in;
   logic                 paging_ff,  paging_in;
   logic [PfnWidth-1:0]  pdbase_ff,  pdbase_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   walk_result_type      rsp_ff,     rsp_in;

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = !reset;

   assign state.phase          = phase_ff;
   assign state.held_lin_addr  = held_ff;
   assign state.paging_enabled = paging_ff;
   assign state.page_dir_base  = pdbase_ff;

   pgw_step u_step (
      .command   (req_tuser),
      .lin_addr  (req_tdata[AddrWidth-1:0]),
      .read_data (req_tdata[2*AddrWidth-1:AddrWidth]),
      .state     (state),
      .result    (result),
      .update    (update)
   );

   always_comb begin
      phase_in     = phase_ff;
      held_in      = held_ff;
      paging_in    = paging_ff;
      pdbase_in    = pdbase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      if (req_accept) begin
         phase_in     = update.next_phase;
         rsp_valid_in = 1'b1;
         rsp_in       = result;
         if (update.load_held) begin
            held_in = req_tdata[AddrWidth-1:0];
         end
      end
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PAGING_ENABLED: paging_in = csr_data[0];
            CSR_PAGE_DIR_BASE:  pdbase_in = csr_data[PfnWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         held_ff      <= '0;
         paging_ff    <= 1'b0;
         pdbase_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         paging_ff    <= paging_in;
         pdbase_ff    <= pdbase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {6'b0, rsp_ff.writable, rsp_ff.ok, rsp_ff.phys_addr, rsp_ff.mem_addr};

endmodule

>>> design/pgw_step.sv
// Combinational step of the walk: one request against the current walk state.
`timescale 1ns / 1ps
module pgw_step (
   input  logic                          command,
   input  logic [pgw_pkg::AddrWidth-1:0] lin_addr,
   input  logic [pgw_pkg::AddrWidth-1:0] read_data,
   input  pgw_pkg::walk_state_type       state,
   output pgw_pkg::walk_result_type      result,
   output pgw_pkg::walk_update_type      update
);
   import pgw_pkg::*;

   logic                 idle;
   logic [IdxWidth-1:0]  dir_idx;
   logic [IdxWidth-1:0]  tbl_idx;
   logic [AddrWidth-1:0] dir_entry_addr;
   logic [AddrWidth-1:0] tbl_entry_addr;
   logic [AddrWidth-1:0] large_phys;
   logic [AddrWidth-1:0] small_phys;

   assign idle    = (state.phase != PHASE_DIR) && (state.phase != PHASE_TBL);
   assign dir_idx = lin_addr[DirShift +: IdxWidth];
   assign tbl_idx = state.held_lin_addr[TblShift +: IdxWidth];

   assign dir_entry_addr = {state.page_dir_base, dir_idx, 2'b00};
   assign tbl_entry_addr = {read_data[AddrWidth-1:TblShift], tbl_idx, 2'b00};
   assign large_phys = {read_data[AddrWidth-1:DirShift], state.held_lin_addr[DirShift-1:0]};
   assign small_phys = {read_data[AddrWidth-1:TblShift], state.held_lin_addr[TblShift-1:0]};

   always_comb begin
      result.kind      = KIND_ERR;
      result.mem_addr  = '0;
      result.phys_addr = '0;
      result.ok        = 1'b0;
      result.writable  = 1'b0;
      update.next_phase = state.phase;
      update.load_held  = 1'b0;
      if (command == CMD_TRANSLATE) begin
         if (idle) begin
            if (!state.paging_enabled) begin
               result.kind      = KIND_DONE;
               result.phys_addr = lin_addr;
               result.ok        = 1'b1;
               result.writable  = 1'b1;
            end else begin
               result.kind       = KIND_READ;
               result.mem_addr   = dir_entry_addr;
               update.next_phase = PHASE_DIR;
               update.load_held  = 1'b1;
            end
         end
      end else if (!idle) begin
         if (state.phase == PHASE_DIR) begin
            if (!read_data[0]) begin
               result.kind       = KIND_DONE;
               update.next_phase = PHASE_IDLE;
            end else if (read_data[LargeBit]) begin
               result.kind       = KIND_DONE;
               result.phys_addr  = large_phys;
               result.ok         = 1'b1;
               result.writable   = read_data[1];
               update.next_phase = PHASE_IDLE;
            end else begin
               result.kind       = KIND_READ;
               result.mem_addr   = tbl_entry_addr;
               update.next_phase = PHASE_TBL;
            end
         end else begin
            update.next_phase = PHASE_IDLE;
            result.kind       = KIND_DONE;
            if (!read_data[0]) begin
               result.writable = 1'b1;
            end else begin
               result.phys_addr = small_phys;
               result.ok        = 1'b1;
               result.writable  = read_data[1];
            end
         end
      end
   end

endmodule
